FILE: rtl/core/hslrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Shared types and constants of the HSL to RGB pixel converter.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

   localparam int HUE_W      = 16;
   localparam int UNIT_W     = 17;
   localparam int CHAN_W     = 8;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;

   localparam logic [UNIT_W-1:0] UNIT_MAX = 17'h10000;
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

   // hue ramp segment of one channel
   typedef enum logic [1:0] {
      SEG_RISE,
      SEG_HIGH,
      SEG_FALL,
      SEG_LOW
   } segment_type;

endpackage

FILE: rtl/core/hslrgb_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslrgb_channel
// One color channel: hue ramp segment, ramp product, selection and the
// final scale to a byte. Stages 4 to 7 of the converter pipeline.
// ----------------------------------------------------------------------------
module hslrgb_channel #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [FRAC_BITS-1:0]                t_pos,
   input  logic [FRAC_BITS+1:0]                p_val,
   input  logic [FRAC_BITS+1:0]                q_val,
   input  logic [FRAC_BITS+1:0]                span,
   input  logic [FRAC_BITS:0]                  light,
   input  logic                                gray,
   output logic [hslrgb_pkg::CHAN_W-1:0]       chan
);

   localparam int F  = FRAC_BITS;
   localparam int W1 = FRAC_BITS + 1;
   localparam int W2 = FRAC_BITS + 2;
   localparam logic [W1-1:0] ONE        = W1'(1) << F;
   localparam logic [F-1:0]  SIXTH      = F'(ONE / 6);
   localparam logic [F-1:0]  HALF       = F'(ONE / 2);
   localparam logic [F-1:0]  TWO_THIRDS = F'((2 * ONE) / 3);

   hslrgb_pkg::segment_type seg4_in, seg4_ff, seg5_ff;
   logic [W1-1:0]    k4_in, k4_ff;
   logic [F-1:0]     fall_dist;
   logic [2*F+2:0]   prod_full;
   logic [W2-1:0]    prod5_in, prod5_ff;
   logic [W2-1:0]    p5_ff, q5_ff;
   logic [W1-1:0]    l5_ff;
   logic             gray5_ff;
   logic [W2-1:0]    v6_in, v6_ff;
   logic [F+9:0]     scaled;
   logic [9:0]       scaled_int;
   logic [hslrgb_pkg::CHAN_W-1:0] chan7_in, chan7_ff;

   // stage 4: segment and ramp factor
   assign fall_dist = TWO_THIRDS - t_pos;

   always_comb begin
      if (t_pos < SIXTH) begin
         seg4_in = hslrgb_pkg::SEG_RISE;
         k4_in   = W1'({3'b000, t_pos} * 3'd6);
      end else if (t_pos < HALF) begin
         seg4_in = hslrgb_pkg::SEG_HIGH;
         k4_in   = '0;
      end else if (t_pos < TWO_THIRDS) begin
         seg4_in = hslrgb_pkg::SEG_FALL;
         k4_in   = W1'({3'b000, fall_dist} * 3'd6);
      end else begin
         seg4_in = hslrgb_pkg::SEG_LOW;
         k4_in   = '0;
      end
   end

   // stage 5: ramp product
   assign prod_full = span * k4_ff;
   assign prod5_in  = W2'(prod_full >> F);

   // stage 6: channel value
   always_comb begin
      if (gray5_ff) begin
         v6_in = {1'b0, l5_ff};
      end else begin
         case (seg5_ff)
            hslrgb_pkg::SEG_RISE: v6_in = p5_ff + prod5_ff;
            hslrgb_pkg::SEG_HIGH: v6_in = q5_ff;
            hslrgb_pkg::SEG_FALL: v6_in = p5_ff + prod5_ff;
            hslrgb_pkg::SEG_LOW:  v6_in = p5_ff;
            default:              v6_in = p5_ff;
         endcase
      end
   end

   // stage 7: value * 255, integer part, clamp
   assign scaled     = {v6_ff, 8'h00} - {8'h00, v6_ff};
   assign scaled_int = scaled[F+9:F];
   assign chan7_in   = (|scaled_int[9:8]) ? hslrgb_pkg::CHAN_MAX : scaled_int[7:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         seg4_ff  <= seg4_in;
         k4_ff    <= k4_in;
         seg5_ff  <= seg4_ff;
         prod5_ff <= prod5_in;
         p5_ff    <= p_val;
         q5_ff    <= q_val;
         l5_ff    <= light;
         gray5_ff <= gray;
         v6_ff    <= v6_in;
         chan7_ff <= chan7_in;
      end
   end

   assign chan = chan7_ff;

endmodule

FILE: rtl/core/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Converts a hue, saturation, lightness request to an RGB pixel of 8 bits per channel.
//
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata: hue, saturation, lightness
// rsp_      out  rsp_tvalid/rsp_tready  tdata: red, green, blue
//
// One request per cycle unless rsp_ stalls.
// Stages: rescale, l*s product, q, p and span, ramp segment, ramp product,
// channel select, byte scale. The l*s and ramp multipliers set the depth.
// Synchronous reset clears the valid bits only.
// A stall at rsp_ freezes the whole pipeline; req_tready follows it.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // hue[15:0], saturation[32:16], lightness[49:33], zero pad
   input  logic [hslrgb_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // red[7:0], green[15:8], blue[23:16]
   output logic [hslrgb_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int F     = FRAC_BITS;
   localparam int W1    = FRAC_BITS + 1;
   localparam int W2    = FRAC_BITS + 2;
   localparam int DEPTH = 7;
   localparam logic [W1-1:0] ONE       = W1'(1) << F;
   localparam logic [F-1:0]  HALF      = F'(ONE / 2);
   localparam logic [F-1:0]  THIRD     = F'(ONE / 3);
   localparam logic [F-1:0]  THIRD_NEG = F'(ONE - W1'(ONE / 3));

   logic                                enable;
   logic [DEPTH-1:0]                    valid_in, valid_ff;
   logic [hslrgb_pkg::HUE_W-1:0]        hue;
   logic [hslrgb_pkg::UNIT_W-1:0]       sat_raw, light_raw, sat_c, light_c;

   logic [F-1:0]   tg1_in, tr1_in, tb1_in;
   logic [F-1:0]   tg1_ff, tr1_ff, tb1_ff, tg2_ff, tr2_ff, tb2_ff, tg3_ff, tr3_ff, tb3_ff;
   logic [W1-1:0]  s1_in, l1_in, s1_ff, l1_ff, s2_ff, l2_ff, l3_ff, l4_ff;
   logic           gray1_in, gray1_ff, gray2_ff, gray3_ff, gray4_ff;
   logic [2*F+1:0] ls_full;
   logic [W1-1:0]  ls2_in, ls2_ff;
   logic [W2-1:0]  q3_in, q3_ff, q4_ff;
   logic [W2-1:0]  two_l, p4_in, p4_ff, span4_in, span4_ff, q_minus_l;
   logic [hslrgb_pkg::CHAN_W-1:0] red, green, blue;

   assign enable     = ~valid_ff[DEPTH-1] | rsp_tready;
   assign req_tready = enable;
   assign valid_in   = {valid_ff[DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: unpack, clamp, rescale, hue offsets
   assign hue       = req_tdata[15:0];
   assign sat_raw   = req_tdata[32:16];
   assign light_raw = req_tdata[49:33];
   assign sat_c     = (sat_raw > hslrgb_pkg::UNIT_MAX) ? hslrgb_pkg::UNIT_MAX : sat_raw;
   assign light_c   = (light_raw > hslrgb_pkg::UNIT_MAX) ? hslrgb_pkg::UNIT_MAX : light_raw;
   assign s1_in     = W1'({sat_c, {F{1'b0}}} >> 16);
   assign l1_in     = W1'({light_c, {F{1'b0}}} >> 16);
   assign tg1_in    = F'({hue, {F{1'b0}}} >> 16);
   assign tr1_in    = tg1_in + THIRD;
   assign tb1_in    = tg1_in + THIRD_NEG;
   assign gray1_in  = (sat_raw == '0);

   // stage 2: l * s
   assign ls_full = l1_ff * s1_ff;
   assign ls2_in  = W1'(ls_full >> F);

   // stage 3: q
   assign q3_in = (l2_ff < {1'b0, HALF}) ? {1'b0, l2_ff} + {1'b0, ls2_ff}
                                         : {1'b0, l2_ff} + {1'b0, s2_ff} - {1'b0, ls2_ff};

   // stage 4: p and q - p (q never drops below l)
   assign two_l     = {l3_ff, 1'b0};
   assign q_minus_l = q3_ff - {1'b0, l3_ff};
   assign p4_in     = (two_l >= q3_ff) ? two_l - q3_ff : '0;
   assign span4_in  = (two_l >= q3_ff) ? W2'({q_minus_l, 1'b0}) : q3_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         tg1_ff   <= tg1_in;
         tr1_ff   <= tr1_in;
         tb1_ff   <= tb1_in;
         s1_ff    <= s1_in;
         l1_ff    <= l1_in;
         gray1_ff <= gray1_in;
         tg2_ff   <= tg1_ff;
         tr2_ff   <= tr1_ff;
         tb2_ff   <= tb1_ff;
         s2_ff    <= s1_ff;
         l2_ff    <= l1_ff;
         ls2_ff   <= ls2_in;
         gray2_ff <= gray1_ff;
         tg3_ff   <= tg2_ff;
         tr3_ff   <= tr2_ff;
         tb3_ff   <= tb2_ff;
         l3_ff    <= l2_ff;
         q3_ff    <= q3_in;
         gray3_ff <= gray2_ff;
         l4_ff    <= l3_ff;
         q4_ff    <= q3_ff;
         p4_ff    <= p4_in;
         span4_ff <= span4_in;
         gray4_ff <= gray3_ff;
      end
   end

   hslrgb_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
      .clock  (clock),
      .enable (enable),
      .t_pos  (tr3_ff),
      .p_val  (p4_ff),
      .q_val  (q4_ff),
      .span   (span4_ff),
      .light  (l4_ff),
      .gray   (gray4_ff),
      .chan   (red)
   );

   hslrgb_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
      .clock  (clock),
      .enable (enable),
      .t_pos  (tg3_ff),
      .p_val  (p4_ff),
      .q_val  (q4_ff),
      .span   (span4_ff),
      .light  (l4_ff),
      .gray   (gray4_ff),
      .chan   (green)
   );

   hslrgb_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
      .clock  (clock),
      .enable (enable),
      .t_pos  (tb3_ff),
      .p_val  (p4_ff),
      .q_val  (q4_ff),
      .span   (span4_ff),
      .light  (l4_ff),
      .gray   (gray4_ff),
      .chan   (blue)
   );

   assign rsp_tvalid = valid_ff[DEPTH-1];
   assign rsp_tdata  = {blue, green, red};

endmodule

FILE: rtl/core/hslrgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslrgb_checker
// Port-level checks of the HSL to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hslrgb_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [hslrgb_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [hslrgb_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // no output is left pending without the input side stalling
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not track output backpressure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // gray at full lightness comes out white while rsp_tready stays high
   a_white_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && rsp_tready && req_tdata[32:16] == '0 &&
       req_tdata[49:33] == hslrgb_pkg::UNIT_MAX)
      ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid && rsp_tdata == {3{hslrgb_pkg::CHAN_MAX}})
      else $error("white pixel missing at pipeline output");

endmodule

bind hsl_to_rgb_converter hslrgb_checker u_hslrgb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
